// File: rtl/core/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared types and constants for the nearest palette color match block.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

   localparam int CHAN_W  = 8;
   localparam int COLOR_W = 3 * CHAN_W;
   localparam int SQ_W    = 2 * CHAN_W;
   localparam int DIST_W  = 18;
   localparam int IDX_W   = 10;
   localparam int COUNT_W = 11;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_MATCH = 1'b1;

   // tag that travels with each palette entry through the distance pipe
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic [IDX_W-1:0] idx;
   } scan_tag_type;

endpackage

`default_nettype wire

// File: rtl/core/npcm_ram.sv
// ----------------------------------------------------------------------------
// npcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/npcm_dist.sv
// ----------------------------------------------------------------------------
// npcm_dist
// Three-stage squared RGB distance unit, one palette entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_dist
   import npcm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire scan_tag_type        tag_in,
   input  wire logic [COLOR_W-1:0]  color,
   input  wire logic [CHAN_W-1:0]   pix_red,
   input  wire logic [CHAN_W-1:0]   pix_green,
   input  wire logic [CHAN_W-1:0]   pix_blue,
   output scan_tag_type             tag_out,
   output logic      [DIST_W-1:0]   dist_sum
);

   scan_tag_type      tag_a_ff, tag_b_ff, tag_c_ff;
   logic [CHAN_W-1:0] dr_ff, dg_ff, db_ff;
   logic [CHAN_W-1:0] dr_in, dg_in, db_in;
   logic [SQ_W-1:0]   sr_ff, sg_ff, sb_ff;
   logic [DIST_W-1:0] sum_ff;
   logic [CHAN_W-1:0] er, eg, eb;

   assign er = color[COLOR_W-1 -: CHAN_W];
   assign eg = color[2*CHAN_W-1 -: CHAN_W];
   assign eb = color[CHAN_W-1:0];

   // absolute channel differences
   assign dr_in = (er > pix_red)   ? er - pix_red   : pix_red - er;
   assign dg_in = (eg > pix_green) ? eg - pix_green : pix_green - eg;
   assign db_in = (eb > pix_blue)  ? eb - pix_blue  : pix_blue - eb;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else begin
         tag_a_ff <= tag_in;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      dr_ff  <= dr_in;
      dg_ff  <= dg_in;
      db_ff  <= db_in;
      sr_ff  <= SQ_W'(dr_ff) * SQ_W'(dr_ff);
      sg_ff  <= SQ_W'(dg_ff) * SQ_W'(dg_ff);
      sb_ff  <= SQ_W'(db_ff) * SQ_W'(db_ff);
      sum_ff <= DIST_W'(sr_ff) + DIST_W'(sg_ff) + DIST_W'(sb_ff);
   end

   assign tag_out  = tag_c_ff;
   assign dist_sum = sum_ff;

endmodule

`default_nettype wire

// File: rtl/core/nearest_palette_color_match.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match
// Palette store plus nearest-color search by summed squared RGB difference.
// ----------------------------------------------------------------------------
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   ---------------------------
//  request   req_mode req_entry_index req_red/green/  start && !busy
//            req_blue
//  response  rsp_best_index rsp_best_distance        rsp_valid, one cycle, no stall
//  csr       csr_wr_data (palette_count)             csr_wr_en
//
//  A load item writes its palette entry at the accepting edge; busy stays
//  low.
//  A match item scans n = clamp(palette_count, 1, PALETTE_DEPTH) entries,
//  one per cycle through the RAM read port and the distance pipe; busy is
//  high until the pipe drains; the result strobes in the cycle busy drops.
//  The RAM read port and the single distance unit set the one-entry-per-cycle
//  pace.
//  Reset clears the sequencer, the strobe and sets palette_count to 1; the
//  palette itself is undefined until written.
//  The receiver cannot stall: each result item is shown for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_match
   import npcm_pkg::*;
#(
   parameter int PALETTE_DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [IDX_W-1:0]   req_entry_index,
   input  wire logic [CHAN_W-1:0]  req_red,
   input  wire logic [CHAN_W-1:0]  req_green,
   input  wire logic [CHAN_W-1:0]  req_blue,
   // response
   output logic                    rsp_valid,
   output logic      [IDX_W-1:0]   rsp_best_index,
   output logic      [DIST_W-1:0]  rsp_best_distance,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   // width wide enough for both the count register and the depth itself
   localparam int NW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
   localparam int WIDE_W = 32;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      last_ff, last_in;
   logic [CHAN_W-1:0]  pix_r_ff, pix_g_ff, pix_b_ff;
   scan_tag_type       tag0, tag1_ff, dist_tag;
   logic [DIST_W-1:0]  scan_dist;
   logic [COLOR_W-1:0] rd_color;
   logic [DIST_W-1:0]  best_d_ff, best_d_in;
   logic [IDX_W-1:0]   best_i_ff, best_i_in;
   logic               take_new;
   logic               rsp_valid_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               accept, accept_match, accept_load;
   logic               wr_en;
   logic [NW-1:0]      n_count;
   logic               finish;

   assign busy         = (state_ff != ST_IDLE);
   assign accept       = start && !busy;
   assign accept_match = accept && (req_mode == MODE_MATCH);
   assign accept_load  = accept && (req_mode == MODE_LOAD);

   // loads beyond the palette depth are dropped
   assign wr_en = accept_load &&
                  (WIDE_W'(req_entry_index) < WIDE_W'(PALETTE_DEPTH));

   // ------------------------------------------------------------------
   // Palette store
   // ------------------------------------------------------------------
   npcm_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_en   (tag0.valid),
      .rd_addr (scan_ff),
      .rd_data (rd_color)
   );

   // ------------------------------------------------------------------
   // Scan length: count of zero means one, clamp to the depth
   // ------------------------------------------------------------------
   always_comb begin
      n_count = NW'(count_ff);
      if (n_count == '0) begin
         n_count = NW'(1);
      end
      if (n_count > NW'(PALETTE_DEPTH)) begin
         n_count = NW'(PALETTE_DEPTH);
      end
      last_in = AW'(n_count - NW'(1));
   end

   // ------------------------------------------------------------------
   // Sequencer: issue one read per cycle, then wait for the pipe to drain
   // ------------------------------------------------------------------
   always_comb begin
      tag0       = '0;
      tag0.valid = (state_ff == ST_SCAN);
      tag0.first = (scan_ff == '0);
      tag0.last  = (scan_ff == last_ff);
      tag0.idx   = IDX_W'(scan_ff);
   end

   assign finish = dist_tag.valid && dist_tag.last;

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept_match) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            if (scan_ff == last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= COUNT_W'(1);
         tag1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tag1_ff  <= tag0;       // lines up with registered RAM data
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      if (accept_match) begin
         last_ff  <= last_in;
         pix_r_ff <= req_red;
         pix_g_ff <= req_green;
         pix_b_ff <= req_blue;
      end
   end

   // ------------------------------------------------------------------
   // Shared distance unit
   // ------------------------------------------------------------------
   npcm_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .tag_in    (tag1_ff),
      .color     (rd_color),
      .pix_red   (pix_r_ff),
      .pix_green (pix_g_ff),
      .pix_blue  (pix_b_ff),
      .tag_out   (dist_tag),
      .dist_sum  (scan_dist)
   );

   // ------------------------------------------------------------------
   // Best tracker: strict less-than keeps the lowest index on a tie
   // ------------------------------------------------------------------
   assign take_new  = dist_tag.first || (scan_dist < best_d_ff);
   assign best_d_in = take_new ? scan_dist : best_d_ff;
   assign best_i_in = take_new ? dist_tag.idx : best_i_ff;

   always_ff @(posedge clock) begin
      if (dist_tag.valid) begin
         best_d_ff <= best_d_in;
         best_i_ff <= best_i_in;
      end
      if (finish) begin
         rsp_idx_ff  <= best_i_in;
         rsp_dist_ff <= best_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_index    = rsp_idx_ff;
   assign rsp_best_distance = rsp_dist_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_pipe_empty_idle: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (!dist_tag.valid && !tag1_ff.valid))
      else $error("distance pipe holds entries while idle");

   a_match_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_MATCH) |=> busy)
      else $error("match item did not start a scan");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a preceding scan");

endmodule

`default_nettype wire
